/* rtl/steered_response_scan_unit_defines.svh */
// Assertion macros used by the checker file of the project.
`ifndef STEERED_RESPONSE_SCAN_UNIT_DEFINES_SVH
`define STEERED_RESPONSE_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srsu_pkg.sv */
`default_nettype none
package srsu_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int NBINS_DEF        = 257;
    localparam int MAX_ANGLES_DEF   = 64;

    localparam int MUL_W = 20;
    localparam int Q_W   = 30;
    localparam int LO_W  = 18;

    localparam logic [3:0]  NUM_CHANNELS_RST = 4'd4;
    localparam logic [15:0] SCORE_MAX        = 16'd32768;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_SCAN = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_CHK,
        S_ABS,
        S_SQ,
        S_SAT,
        S_DIV,
        S_SQRT,
        S_SCALE
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic [6:0]         angle;
        logic [8:0]         bin;
        logic [2:0]         chan;
        logic signed [15:0] re_part;
        logic signed [15:0] im_part;
        logic [15:0]        weight;
    } t_in;

    typedef struct packed {
        logic [5:0]  out_angle;
        logic [8:0]  out_bin;
        logic [15:0] score;
        logic        zero_energy;
        logic        last;
    } t_out;

endpackage
`default_nettype wire

/* rtl/steered_response_scan_unit.sv */
// A coefficient load is written at its accepting edge. A sample that closes a bin gives its
// results, also when the score saturates or the energy is zero; one shared 20x20 multiplier.
// A mode 2 scan of K angles keeps busy high until its last score; start is ignored while busy.
// Results are single-cycle strobes on o_valid; the receiver cannot stall them.
// Synchronous active-low reset clears the sequencer, the strobe and sets num_channels to 4.
`default_nettype none
module steered_response_scan_unit
    import srsu_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int NBINS        = NBINS_DEF,
    parameter int MAX_ANGLES   = MAX_ANGLES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_in        i_in,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    output logic            o_valid,
    output t_out            o_out
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ANG_W = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
    localparam int DEPTH = MAX_ANGLES * NBINS * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = 34 + $clog2(MAX_CHANNELS);
    localparam int MAG_W = ACC_W - 1;
    localparam int E_W   = 32 + $clog2(MAX_CHANNELS);
    localparam int P_W   = 2 * MAG_W + 1;
    localparam int K_W   = $clog2(Q_W);

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [CH_W-1:0] r_ch, n_ch;
    logic [ANG_W-1:0] r_angle, n_angle, r_last_angle, n_last_angle;
    logic [8:0] r_bin, n_bin;
    logic [15:0] r_weight, n_weight;
    logic [31:0] r_buf [MAX_CHANNELS];
    logic [E_W-1:0] r_e, n_e;
    logic signed [ACC_W-1:0] r_fa, n_fa, r_fb, n_fb;
    logic r_sel, n_sel;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [P_W-1:0] r_p, n_p, r_dsh, n_dsh;
    logic [Q_W-1:0] r_q, n_q, r_sq_r, n_sq_r, r_sq_bit, n_sq_bit;
    logic [K_W-1:0] r_k, n_k;
    logic [15:0] r_s, n_s;
    logic r_zero, n_zero;
    logic [3:0] r_num_channels;
    logic r_valid, n_valid;
    t_out r_out, n_out;

    logic accept, load_ok, samp_ok, go, mode_one, mode_scan;
    logic [CH_W-1:0] last_ch;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_rdata;
    logic signed [15:0] xr, xi, wr, wi;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [P_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] abs_src;
    logic p_ge_sat, div_ge, sq_ge;
    logic [Q_W-1:0] sq_t;
    logic [2*MUL_W-16:0] scaled;
    int scan_cnt;

    assign busy = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);
    assign mode_one = (i_in.mode == MODE_ONE);
    assign mode_scan = (i_in.mode == MODE_SCAN);

    always_comb begin
        if (r_num_channels == 4'd0) begin
            last_ch = '0;
        end else if (32'(r_num_channels) > MAX_CHANNELS) begin
            last_ch = CH_W'(MAX_CHANNELS - 1);
        end else begin
            last_ch = CH_W'(r_num_channels - 4'd1);
        end
    end

    always_comb begin
        scan_cnt = (32'(i_in.angle) > MAX_ANGLES) ? MAX_ANGLES : 32'(i_in.angle);
        load_ok = accept && (i_in.mode == MODE_LOAD) && (32'(i_in.angle) < MAX_ANGLES)
                  && (32'(i_in.bin) < NBINS) && (32'(i_in.chan) < MAX_CHANNELS);
        samp_ok = accept && ((mode_one && (32'(i_in.angle) < MAX_ANGLES)) || mode_scan)
                  && (32'(i_in.chan) < MAX_CHANNELS);
        go = samp_ok && (32'(i_in.chan) == 32'(last_ch)) && (32'(i_in.bin) < NBINS)
             && (mode_one || (scan_cnt != 0));
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            ram_addr = (AW'(i_in.angle) * AW'(NBINS) + AW'(i_in.bin)) * AW'(MAX_CHANNELS)
                       + AW'(i_in.chan);
        end else begin
            ram_addr = (AW'(r_angle) * AW'(NBINS) + AW'(r_bin)) * AW'(MAX_CHANNELS)
                       + AW'(r_ch);
        end
    end

    srsu_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (load_ok),
        .i_addr (ram_addr),
        .i_wdata({i_in.im_part, i_in.re_part}),
        .o_rdata(ram_rdata)
    );

    assign xr = r_buf[r_ch][15:0];
    assign xi = r_buf[r_ch][31:16];
    assign wr = ram_rdata[15:0];
    assign wi = ram_rdata[31:16];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MAC: begin
                unique case (r_step)
                    3'd0: begin mul_a = MUL_W'(xr); mul_b = MUL_W'(xr); end
                    3'd1: begin mul_a = MUL_W'(xi); mul_b = MUL_W'(xi); end
                    3'd2: begin mul_a = MUL_W'(xr); mul_b = MUL_W'(wr); end
                    3'd3: begin mul_a = MUL_W'(xi); mul_b = MUL_W'(wi); end
                    3'd4: begin mul_a = MUL_W'(xi); mul_b = MUL_W'(wr); end
                    3'd5: begin mul_a = MUL_W'(xr); mul_b = MUL_W'(wi); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQ: begin
                unique case (r_step)
                    3'd0: begin
                        mul_a = MUL_W'(r_mag[MAG_W-1:LO_W]);
                        mul_b = MUL_W'(r_mag[MAG_W-1:LO_W]);
                    end
                    3'd1: begin
                        mul_a = MUL_W'(r_mag[MAG_W-1:LO_W]);
                        mul_b = MUL_W'(r_mag[LO_W-1:0]);
                    end
                    default: begin
                        mul_a = MUL_W'(r_mag[LO_W-1:0]);
                        mul_b = MUL_W'(r_mag[LO_W-1:0]);
                    end
                endcase
            end
            S_SCALE: begin
                mul_a = MUL_W'(r_weight);
                mul_b = MUL_W'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod_ext = P_W'($unsigned(mul_p));
    assign abs_src = r_sel ? r_fb : r_fa;
    assign p_ge_sat = r_p >= (P_W'(r_e) << Q_W);
    assign div_ge = r_p >= r_dsh;
    assign sq_t = r_sq_r + r_sq_bit;
    assign sq_ge = r_q >= sq_t;
    assign scaled = mul_p[2*MUL_W-1:15];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (go) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_MAC;
            S_MAC: begin
                if (r_step == 3'd5) begin
                    n_state = (r_ch == last_ch) ? S_CHK : S_READ;
                end
            end
            S_CHK: n_state = (r_e == '0) ? S_SCALE : S_ABS;
            S_ABS: n_state = S_SQ;
            S_SQ: begin
                if (r_step == 3'd2) begin
                    n_state = r_sel ? S_SAT : S_ABS;
                end
            end
            S_SAT: n_state = p_ge_sat ? S_SCALE : S_DIV;
            S_DIV: begin
                if (r_k == '0) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_sq_bit == Q_W'(1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = (r_angle == r_last_angle) ? S_IDLE : S_READ;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_step = r_step;
        n_ch = r_ch;
        n_angle = r_angle;
        n_last_angle = r_last_angle;
        n_bin = r_bin;
        n_weight = r_weight;
        n_e = r_e;
        n_fa = r_fa;
        n_fb = r_fb;
        n_sel = r_sel;
        n_mag = r_mag;
        n_p = r_p;
        n_dsh = r_dsh;
        n_q = r_q;
        n_k = r_k;
        n_sq_r = r_sq_r;
        n_sq_bit = r_sq_bit;
        n_s = r_s;
        n_zero = r_zero;
        n_out = r_out;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_ch = '0;
                n_step = '0;
                n_e = '0;
                n_fa = '0;
                n_fb = '0;
                n_bin = i_in.bin;
                n_weight = i_in.weight;
                if (mode_one) begin
                    n_angle = ANG_W'(i_in.angle);
                    n_last_angle = ANG_W'(i_in.angle);
                end else begin
                    n_angle = '0;
                    n_last_angle = ANG_W'(scan_cnt - 1);
                end
            end
            S_READ: n_step = '0;
            S_MAC: begin
                unique case (r_step)
                    3'd0, 3'd1: n_e = r_e + mul_p[E_W-1:0];
                    3'd2, 3'd3: n_fa = r_fa + mul_p[ACC_W-1:0];
                    3'd4: n_fb = r_fb + mul_p[ACC_W-1:0];
                    default: n_fb = r_fb - mul_p[ACC_W-1:0];
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_ch = r_ch + CH_W'(1);
                end
            end
            S_CHK: begin
                n_sel = 1'b0;
                n_p = '0;
                n_zero = (r_e == '0);
                n_s = '0;
            end
            S_ABS: begin
                n_mag = MAG_W'(abs_src[ACC_W-1] ? -abs_src : abs_src);
                n_step = '0;
            end
            S_SQ: begin
                unique case (r_step)
                    3'd0: n_p = r_p + (prod_ext << (2 * LO_W));
                    3'd1: n_p = r_p + (prod_ext << (LO_W + 1));
                    default: n_p = r_p + prod_ext;
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_sel = 1'b1;
                end
            end
            S_SAT: begin
                n_s = SCORE_MAX;
                n_dsh = P_W'(r_e) << (Q_W - 1);
                n_k = K_W'(Q_W - 1);
                n_q = '0;
            end
            S_DIV: begin
                if (div_ge) begin
                    n_p = r_p - r_dsh;
                end
                n_q = {r_q[Q_W-2:0], div_ge};
                n_dsh = r_dsh >> 1;
                n_k = r_k - K_W'(1);
                n_sq_r = '0;
                n_sq_bit = Q_W'(1) << (Q_W - 2);
            end
            S_SQRT: begin
                if (sq_ge) begin
                    n_q = r_q - sq_t;
                    n_sq_r = (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    n_sq_r = r_sq_r >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
                n_s = n_sq_r[15:0];
            end
            S_SCALE: begin
                n_valid = 1'b1;
                n_out.out_angle = 6'(r_angle);
                n_out.out_bin = r_bin;
                n_out.zero_energy = r_zero;
                n_out.last = (r_angle == r_last_angle);
                if (r_zero) begin
                    n_out.score = '0;
                end else if (scaled > ($bits(scaled))'(SCORE_MAX)) begin
                    n_out.score = SCORE_MAX;
                end else begin
                    n_out.score = scaled[15:0];
                end
                n_angle = r_angle + ANG_W'(1);
                n_ch = '0;
                n_step = '0;
                n_e = '0;
                n_fa = '0;
                n_fb = '0;
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_num_channels <= NUM_CHANNELS_RST;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_num_channels <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_ch <= n_ch;
        r_angle <= n_angle;
        r_last_angle <= n_last_angle;
        r_bin <= n_bin;
        r_weight <= n_weight;
        r_e <= n_e;
        r_fa <= n_fa;
        r_fb <= n_fb;
        r_sel <= n_sel;
        r_mag <= n_mag;
        r_p <= n_p;
        r_dsh <= n_dsh;
        r_q <= n_q;
        r_k <= n_k;
        r_sq_r <= n_sq_r;
        r_sq_bit <= n_sq_bit;
        r_s <= n_s;
        r_zero <= n_zero;
        r_out <= n_out;
        if (samp_ok) begin
            r_buf[CH_W'(i_in.chan)] <= {i_in.im_part, i_in.re_part};
        end
    end

    assign o_valid = r_valid;
    assign o_out = r_out;

endmodule
`default_nettype wire

/* rtl/srsu_ram.sv */
`default_nettype none
module srsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/srsu_checker.sv */
`default_nettype none
`include "steered_response_scan_unit_defines.svh"
module srsu_checker
    import srsu_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire t_out o_out
);

    `SRSU_ASSERT_NEXT(a_no_result_after_accept, i_clk, i_rst_n, start && !busy, !o_valid, "result right after an accepted transaction")
    `SRSU_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobes back to back")
    `SRSU_ASSERT_NOW(a_busy_until_last, i_clk, i_rst_n, o_valid && !o_out.last, busy, "not busy before the final result")
    `SRSU_ASSERT_NOW(a_zero_score, i_clk, i_rst_n, o_valid && (o_out.zero_energy || o_out.score > 16'd32768), o_out.score == 16'd0, "bad score")

endmodule

bind steered_response_scan_unit srsu_checker u_srsu_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_out  (o_out)
);
`default_nettype wire
